@@ src/block_padding_add_strip_macros.svh @@
// Assertion macros for the block_padding_add_strip design.
// Included by the top level; no other dependencies.
`ifndef BLOCK_PADDING_ADD_STRIP_MACROS_SVH
`define BLOCK_PADDING_ADD_STRIP_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define BPAS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under a synchronous active-low reset.
`define BPAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/bpas_pkg.sv @@
// Shared types and constants for the block padding add/strip block.
// No dependencies; used by block_padding_add_strip.sv and the bench.
`timescale 1ns / 1ps

package bpas_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int RUN_W          = 7;
    localparam int CFG_W          = 6;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 6'd16;
    localparam logic [RUN_W-1:0] RUN_MAX = 7'd127;

    // Configuration register indexes
    localparam logic CFG_STRIP_MODE = 1'b0;
    localparam logic CFG_BLOCK_SIZE = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_present;
        logic       final_item;
        logic       pad_error;
    } out_item_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_BYTE = 9'b000000010,
        S_FWD  = 9'b000000100,
        S_WR   = 9'b000001000,
        S_END  = 9'b000010000,
        S_PAD  = 9'b000100000,
        S_RD   = 9'b001000000,
        S_DRN  = 9'b010000000,
        S_STAT = 9'b100000000
    } state_t;

endpackage

@@ src/block_padding_add_strip.sv @@
// PKCS#7 style padding: append in pad mode, check and strip in strip mode.
// Depends on bpas_pkg, bpas_ring and block_padding_add_strip_macros.svh.
//
//  channel | ports                        | moves
//  --------+------------------------------+----------------------------------
//  input   | s_valid s_ready s_item       | one byte and/or end marker
//  result  | m_valid m_ready m_item       | one byte or one strip status
//  config  | cfg_we cfg_index cfg_wdata   | register write, no handshake
//
// Steps: pad-mode bytes pass S_IDLE, S_BYTE; strip-mode bytes S_IDLE, S_BYTE,
// S_WR, with S_FWD (ring read, registered data) first when the oldest held
// byte is forwarded. At the end: pad mode runs S_END, then S_PAD per pad byte;
// strip S_END, then S_RD and S_DRN (read, emit) per data byte, then S_STAT.
// Reset (aresetn low, synchronous) clears control state; the ring has no
// reset and needs no clearing pass. An input holding register takes the next
// transaction while the current one works; a stalled result stalls the FSM.
`timescale 1ns / 1ps
`include "block_padding_add_strip_macros.svh"

module block_padding_add_strip #(
    parameter int RING_DEPTH = bpas_pkg::RING_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bpas_pkg::in_item_t           s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bpas_pkg::out_item_t          m_item,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bpas_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CALC_W = FILL_W + 1;
    localparam logic [FILL_W-1:0] BS_MAX = FILL_W'(RING_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);

    // Control state
    bpas_pkg::state_t             state_reg, state_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic                         m_valid_reg, m_valid_next;
    logic [HEAD_W-1:0]            head_reg, head_next;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [FILL_W-1:0]            pos_reg, pos_next;
    logic [bpas_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [7:0]                   prev_reg, prev_next;
    logic                         strip_mode_reg, strip_mode_next;
    logic [bpas_pkg::CFG_W-1:0]   block_size_reg, block_size_next;

    // Payload and work registers
    bpas_pkg::in_item_t           hold_item_reg, hold_item_next;
    bpas_pkg::in_item_t           cur_item_reg, cur_item_next;
    bpas_pkg::out_item_t          m_item_reg, m_item_next;
    logic [FILL_W-1:0]            cnt_reg, cnt_next;
    logic [HEAD_W-1:0]            idx_reg, idx_next;
    logic [7:0]                   pad_val_reg, pad_val_next;
    logic                         err_reg, err_next;

    // Ring port
    logic                         ring_rd_en;
    logic [HEAD_W-1:0]            ring_rd_addr;
    logic [7:0]                   ring_rd_data;
    logic                         ring_wr_en;

    logic [FILL_W-1:0]            bs_eff;
    logic [CALC_W-1:0]            oldest_calc;
    logic [HEAD_W-1:0]            oldest;
    logic                         push_ok;
    logic                         strip_ok;
    logic [FILL_W-1:0]            pos_inc;
    logic [FILL_W-1:0]            pad_n;

    bpas_ring #(
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .rd_en  (ring_rd_en),
        .rd_addr(ring_rd_addr),
        .rd_data(ring_rd_data),
        .wr_en  (ring_wr_en),
        .wr_addr(head_reg),
        .wr_data(cur_item_reg.in_byte)
    );

    // Effective block size: zero acts as one, clamp to the ring depth.
    always_comb begin
        if (block_size_reg == '0) begin
            bs_eff = FILL_W'(1);
        end else if (int'(block_size_reg) > RING_DEPTH) begin
            bs_eff = BS_MAX;
        end else begin
            bs_eff = FILL_W'(block_size_reg);
        end
    end

    // Oldest held entry: (head - fill) mod depth, with fill never above depth.
    always_comb begin
        oldest_calc = CALC_W'(head_reg) + CALC_W'(RING_DEPTH) - CALC_W'(fill_reg);
        if (oldest_calc >= CALC_W'(RING_DEPTH)) begin
            oldest_calc = oldest_calc - CALC_W'(RING_DEPTH);
        end
        oldest = oldest_calc[HEAD_W-1:0];
    end

    assign pos_inc = (pos_reg + FILL_W'(1) == bs_eff) ? '0 : pos_reg + FILL_W'(1);
    assign pad_n   = bs_eff - pos_reg;

    // Padding is good only on a nonzero whole number of blocks whose last
    // byte p lies in 1..bs and ends a run of at least p equal bytes.
    assign strip_ok = (fill_reg != '0) && (pos_reg == '0) && (prev_reg != 8'd0) &&
                      (prev_reg <= 8'(bs_eff)) && (8'(run_reg) >= prev_reg) &&
                      (8'(fill_reg) >= prev_reg);

    // The result register may take a new transaction when empty or draining.
    assign push_ok = !m_valid_reg || m_ready;

    assign s_ready = !hold_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        cur_item_next   = cur_item_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pad_val_next    = pad_val_reg;
        err_next        = err_reg;
        strip_mode_next = strip_mode_reg;
        block_size_next = block_size_reg;
        ring_rd_en      = 1'b0;
        ring_rd_addr    = oldest;
        ring_wr_en      = 1'b0;

        // Drop the result once taken; a push below overrides this.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Hold an incoming transaction until the FSM picks it up.
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
            hold_item_next  = s_item;
        end

        unique case (state_reg)
            bpas_pkg::S_IDLE: begin
                if (hold_valid_reg) begin
                    cur_item_next   = hold_item_reg;
                    hold_valid_next = 1'b0;
                    state_next      = bpas_pkg::S_BYTE;
                end
            end
            bpas_pkg::S_BYTE: begin
                if (!cur_item_reg.byte_present) begin
                    state_next = cur_item_reg.end_of_message ? bpas_pkg::S_END
                                                             : bpas_pkg::S_IDLE;
                end else if (!strip_mode_reg) begin
                    // Pad mode: pass the byte straight through.
                    if (push_ok) begin
                        m_valid_next = 1'b1;
                        m_item_next  = '{out_byte: cur_item_reg.in_byte, out_present: 1'b1,
                                         final_item: 1'b0, pad_error: 1'b0};
                        pos_next     = pos_inc;
                        state_next   = cur_item_reg.end_of_message ? bpas_pkg::S_END
                                                                   : bpas_pkg::S_IDLE;
                    end
                end else if (fill_reg >= bs_eff) begin
                    // Ring is full for this block size: fetch the oldest byte.
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = oldest;
                    state_next   = bpas_pkg::S_FWD;
                end else begin
                    state_next = bpas_pkg::S_WR;
                end
            end
            bpas_pkg::S_FWD: begin
                if (push_ok) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: ring_rd_data, out_present: 1'b1,
                                     final_item: 1'b0, pad_error: 1'b0};
                    fill_next    = bs_eff - FILL_W'(1);
                    state_next   = bpas_pkg::S_WR;
                end
            end
            bpas_pkg::S_WR: begin
                // Write the new byte only after any read of the same entry.
                ring_wr_en = 1'b1;
                if (fill_reg == '0 || cur_item_reg.in_byte != prev_reg) begin
                    run_next = bpas_pkg::RUN_W'(1);
                end else if (run_reg < bpas_pkg::RUN_MAX) begin
                    run_next = run_reg + bpas_pkg::RUN_W'(1);
                end
                prev_next  = cur_item_reg.in_byte;
                head_next  = (head_reg == HEAD_LAST) ? '0 : head_reg + HEAD_W'(1);
                fill_next  = fill_reg + FILL_W'(1);
                pos_next   = pos_inc;
                state_next = cur_item_reg.end_of_message ? bpas_pkg::S_END
                                                         : bpas_pkg::S_IDLE;
            end
            bpas_pkg::S_END: begin
                if (!strip_mode_reg) begin
                    cnt_next     = pad_n;
                    pad_val_next = 8'(pad_n);
                    state_next   = bpas_pkg::S_PAD;
                end else begin
                    err_next = !strip_ok;
                    cnt_next = fill_reg - prev_reg[FILL_W-1:0];
                    idx_next = oldest;
                    if (strip_ok && (8'(fill_reg) != prev_reg)) begin
                        state_next = bpas_pkg::S_RD;
                    end else begin
                        state_next = bpas_pkg::S_STAT;
                    end
                end
            end
            bpas_pkg::S_PAD: begin
                if (push_ok) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: pad_val_reg, out_present: 1'b1,
                                     final_item: (cnt_reg == FILL_W'(1)), pad_error: 1'b0};
                    cnt_next     = cnt_reg - FILL_W'(1);
                    if (cnt_reg == FILL_W'(1)) begin
                        head_next  = '0;
                        fill_next  = '0;
                        pos_next   = '0;
                        run_next   = '0;
                        prev_next  = '0;
                        state_next = bpas_pkg::S_IDLE;
                    end
                end
            end
            bpas_pkg::S_RD: begin
                ring_rd_en   = 1'b1;
                ring_rd_addr = idx_reg;
                idx_next     = (idx_reg == HEAD_LAST) ? '0 : idx_reg + HEAD_W'(1);
                cnt_next     = cnt_reg - FILL_W'(1);
                state_next   = bpas_pkg::S_DRN;
            end
            bpas_pkg::S_DRN: begin
                if (push_ok) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: ring_rd_data, out_present: 1'b1,
                                     final_item: 1'b0, pad_error: 1'b0};
                    state_next   = (cnt_reg == '0) ? bpas_pkg::S_STAT : bpas_pkg::S_RD;
                end
            end
            bpas_pkg::S_STAT: begin
                if (push_ok) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{out_byte: 8'd0, out_present: 1'b0,
                                     final_item: 1'b1, pad_error: err_reg};
                    head_next    = '0;
                    fill_next    = '0;
                    pos_next     = '0;
                    run_next     = '0;
                    prev_next    = '0;
                    state_next   = bpas_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bpas_pkg::S_IDLE;
            end
        endcase

        // Any register write drops the message in progress.
        if (cfg_we) begin
            unique case (cfg_index)
                bpas_pkg::CFG_STRIP_MODE: strip_mode_next = cfg_wdata[0];
                bpas_pkg::CFG_BLOCK_SIZE: block_size_next = cfg_wdata;
                default: begin
                end
            endcase
            head_next = '0;
            fill_next = '0;
            pos_next  = '0;
            run_next  = '0;
            prev_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bpas_pkg::S_IDLE;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            run_reg        <= '0;
            prev_reg       <= '0;
            strip_mode_reg <= 1'b0;
            block_size_reg <= bpas_pkg::BLOCK_SIZE_RESET;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            prev_reg       <= prev_next;
            strip_mode_reg <= strip_mode_next;
            block_size_reg <= block_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_item_reg <= hold_item_next;
        cur_item_reg  <= cur_item_next;
        m_item_reg    <= m_item_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        pad_val_reg   <= pad_val_next;
        err_reg       <= err_next;
    end

    // The ring never holds more than one block.
    `BPAS_ASSERT_NOW(a_fill_le_bs, aclk, aresetn, 1'b1, fill_reg <= bs_eff)
    // Every ring read is consumed in the state that follows it.
    `BPAS_ASSERT_NEXT(a_rd_consumed, aclk, aresetn, ring_rd_en,
        state_reg == bpas_pkg::S_FWD || state_reg == bpas_pkg::S_DRN)
    // Read and write never target the ring in the same cycle.
    `BPAS_ASSERT_NOW(a_no_rw_overlap, aclk, aresetn, ring_rd_en, !ring_wr_en)
    // An error is flagged only on a final status transaction.
    `BPAS_ASSERT_NOW(a_err_on_status, aclk, aresetn, m_valid_reg && m_item_reg.pad_error,
        m_item_reg.final_item && !m_item_reg.out_present)

endmodule

@@ src/bpas_ring.sv @@
// Tail ring storage: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module bpas_ring #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/block_padding_add_strip_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for block_padding_add_strip in pad and strip modes.
// Depends on bpas_pkg and the block_padding_add_strip RTL; reads no files.

module block_padding_add_strip_tb;

    localparam int RING_SLOTS    = bpas_pkg::RING_DEPTH_DEF;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 500;
    // About 600 transactions. Each may bring up to 64 results, each of which the
    // receiver may stall, plus the block's own work. The limit takes the worst
    // case of all that several times over.
    localparam int CYCLE_LIMIT   = 10_000_000;

    // One input transaction waiting to be driven. With hold_for_drain set, the
    // driver holds it back until every predicted result has come out.
    typedef struct packed {
        bpas_pkg::in_item_t item;
        logic               hold_for_drain;
    } queued_item_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    bpas_pkg::in_item_t         s_item    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    bpas_pkg::out_item_t        m_item;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = bpas_pkg::CFG_STRIP_MODE;
    logic [bpas_pkg::CFG_W-1:0] cfg_wdata = '0;

    // Predictor state, kept at the block's widths
    logic [7:0]                 tail_bytes [RING_SLOTS];
    logic [5:0]                 write_slot;
    logic [6:0]                 held_count;
    logic [5:0]                 block_pos;
    logic [6:0]                 run_count;
    logic [7:0]                 last_byte;
    logic                       strip_on;
    logic [bpas_pkg::CFG_W-1:0] size_reg;

    bpas_pkg::out_item_t awaited[$];      // predicted results, oldest first
    queued_item_t        pending[$];      // transactions not yet offered
    logic [7:0]          msg_bytes[$];    // message under construction

    int   stim_count   = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic calm         = 1'b0;         // no random gaps or stalls on either side while set
    logic hold_off_req = 1'b0;         // one-cycle request for the long receiver hold

    block_padding_add_strip DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_message_state();
        write_slot = '0;
        held_count = '0;
        block_pos  = '0;
        run_count  = '0;
        last_byte  = '0;
    endfunction

    // A size of zero behaves as one; anything past the ring is clamped.
    function automatic int effective_size();
        int b;
        b = (size_reg == 0) ? 1 : int'(size_reg);
        if (b > RING_SLOTS) b = RING_SLOTS;
        return b;
    endfunction

    function automatic int oldest_slot();
        return (int'(write_slot) + RING_SLOTS - int'(held_count)) % RING_SLOTS;
    endfunction

    function automatic void push_result(logic [7:0] b, logic pres, logic fin, logic err);
        bpas_pkg::out_item_t r;
        r.out_byte    = b;
        r.out_present = pres;
        r.final_item  = fin;
        r.pad_error   = err;
        awaited.push_back(r);
    endfunction

    // Work out the results one accepted transaction causes and advance the state.
    function automatic void predict_padding(bpas_pkg::in_item_t it);
        int bs;
        int n;
        int p;
        int idx;
        bit ok;
        bs = effective_size();
        if (!strip_on) begin
            if (it.byte_present) begin
                push_result(it.in_byte, 1'b1, 1'b0, 1'b0);
                block_pos = 6'((int'(block_pos) + 1) % bs);
            end
            if (it.end_of_message) begin
                n = bs - int'(block_pos);
                for (int i = 0; i < n; i++) push_result(8'(n), 1'b1, i == n - 1, 1'b0);
                clear_message_state();
            end
            return;
        end
        if (it.byte_present) begin
            // Ring full: forward the oldest held byte to make room
            if (int'(held_count) >= bs) begin
                push_result(tail_bytes[oldest_slot()], 1'b1, 1'b0, 1'b0);
                held_count = 7'(bs - 1);
            end
            if (held_count == 0 || it.in_byte != last_byte) run_count = 7'd1;
            else if (run_count < bpas_pkg::RUN_MAX) run_count = run_count + 7'd1;
            last_byte              = it.in_byte;
            tail_bytes[write_slot] = it.in_byte;
            write_slot             = write_slot + 6'd1;
            held_count             = held_count + 7'd1;
            block_pos              = 6'((int'(block_pos) + 1) % bs);
        end
        if (it.end_of_message) begin
            p  = int'(last_byte);
            ok = held_count > 0 && block_pos == 0 && p >= 1 && p <= bs &&
                 int'(run_count) >= p && int'(held_count) >= p;
            if (ok) begin
                n   = int'(held_count) - p;
                idx = oldest_slot();
                for (int i = 0; i < n; i++) begin
                    push_result(tail_bytes[idx], 1'b1, 1'b0, 1'b0);
                    idx = (idx + 1) % RING_SLOTS;
                end
            end
            push_result(8'h00, 1'b0, 1'b1, !ok);
            clear_message_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one; none while calm.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int pick_block_size();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return 63;
            2: return 1;
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    // Idle transactions (no byte, no end) are not counted toward the item total.
    function automatic void add_item(logic [7:0] b, logic pres, logic eom, logic drain);
        queued_item_t q;
        q.item.in_byte        = b;
        q.item.byte_present   = pres;
        q.item.end_of_message = eom;
        q.hold_for_drain      = drain;
        pending.push_back(q);
        if (pres || eom) stim_count++;
    endfunction

    // Turn msg_bytes into transactions: scatter idle noise, and put the end
    // marker either on the last byte or in a transaction of its own.
    function automatic void queue_message(bit terminate);
        int last;
        bit joined;
        bit drain;
        last   = msg_bytes.size() - 1;
        joined = terminate && last >= 0 && $urandom_range(0, 1) == 1;
        drain  = ($urandom_range(0, 15) == 0);
        foreach (msg_bytes[i]) begin
            if ($urandom_range(0, 11) == 0) add_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            add_item(msg_bytes[i], 1'b1, joined && i == last, drain && i == 0);
        end
        if (terminate && !joined) add_item(8'($urandom), 1'b0, 1'b1, drain && last < 0);
    endfunction

    // Well-formed padded message with random data, or one of the broken shapes.
    function automatic void queue_strip_message();
        int bs;
        int len;
        int p;
        int kind;
        int at;
        bs   = effective_size();
        len  = $urandom_range(0, 2 * bs);
        kind = $urandom_range(0, 11);
        msg_bytes.delete();
        repeat (len) msg_bytes.push_back(8'($urandom));
        p = bs - (len % bs);
        repeat (p) msg_bytes.push_back(8'(p));
        case (kind)
            0: begin
                // corrupt one padding byte
                at = msg_bytes.size() - 1 - $urandom_range(0, p - 1);
                msg_bytes[at] ^= 8'($urandom_range(1, 255));
            end
            1: begin
                // wrong length
                msg_bytes.delete($urandom_range(0, msg_bytes.size() - 1));
            end
            2: begin
                // padding count of zero
                for (int i = 0; i < p; i++) msg_bytes[msg_bytes.size() - 1 - i] = 8'h00;
            end
            3: begin
                // padding count above the block size
                at = $urandom_range(bs + 1, 255);
                for (int i = 0; i < p; i++) msg_bytes[msg_bytes.size() - 1 - i] = 8'(at);
            end
            4: begin
                msg_bytes.delete();
            end
            default: begin
            end
        endcase
        // Kind 5 leaves the message open so it runs into the next one
        queue_message(kind != 5);
    endfunction

    function automatic void queue_pad_message();
        int bs;
        int len;
        bs  = effective_size();
        len = $urandom_range(0, 2 * bs + 2);
        msg_bytes.delete();
        repeat (len) msg_bytes.push_back(8'($urandom));
        queue_message($urandom_range(0, 9) != 0);
    endfunction

    // Register writes happen only while the block is idle, so update the
    // predictor right away. Any write drops the message in progress.
    task automatic write_reg(logic idx, logic [bpas_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == bpas_pkg::CFG_STRIP_MODE) strip_on = val[0];
        else size_reg = val;
        clear_message_state();
    endtask

    // Wait until every transaction is taken and every result has come, then
    // give the block time to finish work that produces no result.
    // Sample on the falling edge so the driver's updates have landed.
    task automatic settle();
        while (pending.size() != 0 || s_valid || awaited.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending transactions, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : input_driver
        queued_item_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left  = 0;
        end else begin
            if (s_valid && s_ready) predict_padding(s_item);
            if (s_valid && !s_ready) begin
                // hold valid and payload until the block takes them
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         (!pending[0].hold_for_drain || awaited.size() == 0)) begin
                nxt      = pending.pop_front();
                s_item  <= nxt.item;
                s_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, drive ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        bpas_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: byte %02h present %0b final %0b error %0b",
                                 m_item.out_byte, m_item.out_present, m_item.final_item,
                                 m_item.pad_error);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (m_item.out_byte    !== want.out_byte    ||
                        m_item.out_present !== want.out_present ||
                        m_item.final_item  !== want.final_item  ||
                        m_item.pad_error   !== want.pad_error) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     want.out_byte, want.out_present, want.final_item,
                                     want.pad_error, m_item.out_byte, m_item.out_present,
                                     m_item.final_item, m_item.pad_error);
                        fail_count++;
                    end
                end
            end
            // Long hold-off: let the block back up and stall its input
            if (hold_off_req && hold_left == 0) hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases
    // ------------------------------------------------------------------
    initial begin : test_sequence
        int   phase;
        int   base;
        int   n_msgs;
        int   bs_pick;
        logic mode_pick;

        clear_message_state();
        strip_on = 1'b0;
        size_reg = bpas_pkg::BLOCK_SIZE_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Pad mode at reset size: extreme bytes, end on a byte, empty message,
        // an idle step, then an open message that the next write drops.
        add_item(8'h00, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0, 1'b0);
        add_item(8'hAB, 1'b1, 1'b0, 1'b0);
        settle();
        write_reg(bpas_pkg::CFG_STRIP_MODE, 6'd1);
        write_reg(bpas_pkg::CFG_BLOCK_SIZE, 6'd4);

        // Strip mode: valid padding of three, an empty message, a broken run
        for (int i = 0; i < 5; i++) add_item(8'h41 + 8'(i), 1'b1, 1'b0, 1'b0);
        add_item(8'h03, 1'b1, 1'b0, 1'b0);
        add_item(8'h03, 1'b1, 1'b0, 1'b0);
        add_item(8'h03, 1'b1, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        add_item(8'h07, 1'b1, 1'b0, 1'b0);
        add_item(8'h02, 1'b1, 1'b0, 1'b0);
        add_item(8'h01, 1'b1, 1'b0, 1'b0);
        add_item(8'h02, 1'b1, 1'b1, 1'b0);
        settle();

        // Block size zero acts as one, in both modes
        write_reg(bpas_pkg::CFG_BLOCK_SIZE, 6'd0);
        add_item(8'h01, 1'b1, 1'b1, 1'b0);
        settle();
        write_reg(bpas_pkg::CFG_STRIP_MODE, 6'd0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        settle();

        // Random phases. Phase 0 uses the largest block in strip mode; phase 1
        // floods pad mode while the receiver holds off. Both always run.
        phase = 0;
        base  = stim_count;
        while (phase < 2 || stim_count - base < RANDOM_ITEMS) begin
            if (phase == 0) begin
                mode_pick = 1'b1;
                bs_pick   = 63;
            end else if (phase == 1) begin
                mode_pick = 1'b0;
                bs_pick   = $urandom_range(1, 4);
            end else begin
                mode_pick = 1'($urandom_range(0, 1));
                bs_pick   = pick_block_size();
            end
            if ($urandom_range(0, 1)) begin
                write_reg(bpas_pkg::CFG_STRIP_MODE, {5'd0, mode_pick});
                write_reg(bpas_pkg::CFG_BLOCK_SIZE, 6'(bs_pick));
            end else begin
                write_reg(bpas_pkg::CFG_BLOCK_SIZE, 6'(bs_pick));
                write_reg(bpas_pkg::CFG_STRIP_MODE, {5'd0, mode_pick});
            end
            @(posedge aclk);
            calm <= (phase == 1) || ($urandom_range(0, 3) == 0);
            n_msgs = (phase == 1) ? 12 : (phase == 0) ? 2 : $urandom_range(2, 6);
            repeat (n_msgs) begin
                // Stop adding messages once the item budget is spent
                if (phase < 2 || stim_count - base < RANDOM_ITEMS) begin
                    if (strip_on) queue_strip_message();
                    else queue_pad_message();
                end
            end
            if (phase == 1) begin
                @(posedge aclk);
                hold_off_req <= 1'b1;
                @(posedge aclk);
                hold_off_req <= 1'b0;
            end
            settle();
            phase++;
        end

        settle();
        fail_count += awaited.size();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
